// ----- design/hlc_pkg.sv -----
// Shared types and constants for the homogeneous line clipper.
// Used by the divider, plane clip, viewport map and top-level modules.
// No dependencies.
`timescale 1ns / 1ps

package hlc_pkg;

   // Coordinate formats
   localparam int CoordW   = 32;               // clip-space Q16.16
   localparam int DistW    = CoordW + 1;       // plane distance, coordinate difference
   localparam int NumAxes  = 4;                // x, y, z, w
   localparam int NumPlanes = 6;

   // Point component positions
   localparam int IDX_X = 0;
   localparam int IDX_Y = 1;
   localparam int IDX_Z = 2;
   localparam int IDX_W = 3;

   // Clip planes, in clipping order
   localparam int PLANE_LEFT   = 0;   // w + x >= 0
   localparam int PLANE_RIGHT  = 1;   // w - x >= 0
   localparam int PLANE_BOTTOM = 2;   // w + y >= 0
   localparam int PLANE_TOP    = 3;   // w - y >= 0
   localparam int PLANE_NEAR   = 4;   // z >= 0
   localparam int PLANE_FAR    = 5;   // w - z >= 0

   // Clip parameter divider: t = |da| * 2^30 / |da - db|, t <= 2^30
   localparam int TBits   = 30;
   localparam int PlDenW  = DistW + 1;
   localparam int PlQuoW  = TBits + 1;
   localparam int PlNumW  = PlDenW + PlQuoW;
   localparam int SplitW  = 16;                // low half of the split multiply

   // Viewport divider: quotient below 2^18 or saturated
   localparam int MapDenW = CoordW + 1;
   localparam int MapQuoW = 18;
   localparam int MapNumW = MapDenW + MapQuoW;

   // Configuration
   localparam int OffW     = 12;
   localparam int SizeW    = 13;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 13;
   localparam logic [CsrIdxW-1:0] CSR_VIEW_X      = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_VIEW_Y      = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_VIEW_WIDTH  = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_VIEW_HEIGHT = 2'd3;
   localparam logic [SizeW-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [SizeW-1:0] RESET_HEIGHT = 13'd480;

   // Screen output, unsigned Q13.4
   localparam int ScreenW = 17;
   localparam int NumLanes = 4;                // x0, y0, x1, y1
   localparam logic [ScreenW-1:0] SCREEN_MAX = 17'h1FFFF;

   typedef logic [CoordW-1:0] coord_type;
   typedef coord_type [NumAxes-1:0] point_type;

   typedef struct packed {
      logic      dead;    // rejected by an earlier plane
      point_type a;
      point_type b;
   } seg_type;

   typedef logic [NumLanes-1:0][ScreenW-1:0] screen_type;

endpackage

// ----- design/hlc_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband word alongside; requires num's top DenW bits < den.
// Depends on hlc_pkg.
`timescale 1ns / 1ps

module hlc_div
   import hlc_pkg::*;
#(
   parameter int DenW  = PlDenW,
   parameter int QuoW  = PlQuoW,
   parameter int SideW = 1
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [DenW+QuoW-1:0] num,
   input  logic [DenW-1:0]      den,
   input  logic [SideW-1:0]     side_in,
   output logic [QuoW-1:0]      quo,
   output logic                 rem_nz,
   output logic [SideW-1:0]     side_out
);

   localparam int AccW = DenW + QuoW;

   // acc holds {partial remainder, numerator bits left / quotient bits so far}
   logic [AccW-1:0]  acc_ff   [QuoW];
   logic [DenW-1:0]  den_ff   [QuoW-1];
   logic [SideW-1:0] side_ff  [QuoW];

   logic [AccW-1:0]  acc_src  [QuoW];
   logic [DenW-1:0]  den_src  [QuoW];
   logic [SideW-1:0] side_src [QuoW];
   logic [DenW:0]    trial    [QuoW];
   logic [DenW:0]    diff     [QuoW];
   logic [AccW-1:0]  acc_in   [QuoW];

   // One shift-compare-subtract step per stage
   always_comb begin
      acc_src[0]  = num;
      den_src[0]  = den;
      side_src[0] = side_in;
      for (int k = 1; k < QuoW; k++) begin
         acc_src[k]  = acc_ff[k-1];
         den_src[k]  = den_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
      for (int k = 0; k < QuoW; k++) begin
         trial[k] = acc_src[k][AccW-1:QuoW-1];
         diff[k]  = trial[k] - {1'b0, den_src[k]};
         if (trial[k] >= {1'b0, den_src[k]}) begin
            acc_in[k] = {diff[k][DenW-1:0], acc_src[k][QuoW-2:0], 1'b1};
         end else begin
            acc_in[k] = {trial[k][DenW-1:0], acc_src[k][QuoW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < QuoW; k++) begin
            acc_ff[k]  <= acc_in[k];
            side_ff[k] <= side_src[k];
         end
         for (int k = 0; k < QuoW - 1; k++) begin
            den_ff[k] <= den_src[k];
         end
      end
   end

   assign quo      = acc_ff[QuoW-1][QuoW-1:0];
   assign rem_nz   = |acc_ff[QuoW-1][AccW-1:QuoW];
   assign side_out = side_ff[QuoW-1];

endmodule

// ----- design/hlc_plane.sv -----
// Clips a segment against one homogeneous plane as a pipeline:
// distances, magnitudes, clip parameter divide, split multiply, endpoint move.
// Depends on hlc_pkg and hlc_div.
`timescale 1ns / 1ps

module hlc_plane
   import hlc_pkg::*;
#(
   parameter int Plane = PLANE_LEFT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  seg_type seg_in,
   output logic    out_valid,
   output seg_type seg_out
);

   localparam int HiW   = DistW - SplitW;
   localparam int PhW   = HiW + PlQuoW;
   localparam int PlW   = SplitW + PlQuoW;
   localparam int ProdW = PhW + SplitW;

   typedef struct packed {
      seg_type                        seg;
      logic                           move;    // endpoints straddle the plane
      logic                           sel_a;   // start endpoint is outside
      logic [NumAxes-1:0]             dneg;    // end minus start is negative
      logic [NumAxes-1:0][DistW-1:0]  dmag;    // |end - start|
   } plane_side_type;

   localparam int SideW = $bits(plane_side_type);

   function automatic logic signed [DistW-1:0] plane_dist(input point_type p);
      logic signed [DistW-1:0] x, y, z, w;
      x = DistW'($signed(p[IDX_X]));
      y = DistW'($signed(p[IDX_Y]));
      z = DistW'($signed(p[IDX_Z]));
      w = DistW'($signed(p[IDX_W]));
      unique case (Plane)
         PLANE_LEFT:   plane_dist = w + x;
         PLANE_RIGHT:  plane_dist = w - x;
         PLANE_BOTTOM: plane_dist = w + y;
         PLANE_TOP:    plane_dist = w - y;
         PLANE_NEAR:   plane_dist = z;
         PLANE_FAR:    plane_dist = w - z;
         default:      plane_dist = '0;
      endcase
   endfunction

   // Valid bits
   logic              s0_valid_ff, s1_valid_ff;
   logic [PlQuoW-1:0] dv_ff;
   logic              m0_valid_ff, m1_valid_ff, m2_valid_ff;

   // Stage 0: signed distances
   seg_type                  s0_seg_ff;
   logic signed [DistW-1:0]  da_ff, db_ff;

   // Stage 1: magnitudes for the divider
   plane_side_type           side_in, side_ff;
   logic [DistW-1:0]         damag_in, damag_ff;
   logic [PlDenW-1:0]        den_in, den_ff;

   // Divider output
   logic [PlQuoW-1:0]        t_quo;
   logic [SideW-1:0]         div_side_vec;
   plane_side_type           div_side;

   // Multiply stages
   logic [PhW-1:0]           ph_in [NumAxes];
   logic [PhW-1:0]           ph_ff [NumAxes];
   logic [PlW-1:0]           pl_in [NumAxes];
   logic [PlW-1:0]           pl_ff [NumAxes];
   plane_side_type           m0_side_ff, m1_side_ff;
   logic [ProdW-1:0]         sum   [NumAxes];
   logic [DistW-1:0]         q_in  [NumAxes];
   logic [DistW-1:0]         q_ff  [NumAxes];
   logic [PlDenW-1:0]        p_new [NumAxes];
   seg_type                  seg_in2, seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         dv_ff       <= '0;
         m0_valid_ff <= 1'b0;
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
         dv_ff       <= {dv_ff[PlQuoW-2:0], s1_valid_ff};
         m0_valid_ff <= dv_ff[PlQuoW-1];
         m1_valid_ff <= m0_valid_ff;
         m2_valid_ff <= m1_valid_ff;
      end
   end

   // Stage 1 logic: reject/keep decision and magnitudes
   always_comb begin
      side_in.seg      = s0_seg_ff;
      side_in.seg.dead = s0_seg_ff.dead | (da_ff < 0 && db_ff < 0);
      side_in.move     = !(da_ff >= 0 && db_ff >= 0) && !(da_ff < 0 && db_ff < 0);
      side_in.sel_a    = da_ff < 0;
      for (int i = 0; i < NumAxes; i++) begin
         if ($signed(s0_seg_ff.b[i]) < $signed(s0_seg_ff.a[i])) begin
            side_in.dneg[i] = 1'b1;
            side_in.dmag[i] = DistW'($signed(s0_seg_ff.a[i]))
                            - DistW'($signed(s0_seg_ff.b[i]));
         end else begin
            side_in.dneg[i] = 1'b0;
            side_in.dmag[i] = DistW'($signed(s0_seg_ff.b[i]))
                            - DistW'($signed(s0_seg_ff.a[i]));
         end
      end
      damag_in = da_ff[DistW-1] ? DistW'(-da_ff) : DistW'(da_ff);
      if (da_ff >= db_ff) begin
         den_in = PlDenW'(da_ff) - PlDenW'(db_ff);
      end else begin
         den_in = PlDenW'(db_ff) - PlDenW'(da_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_seg_ff <= seg_in;
         da_ff     <= plane_dist(seg_in.a);
         db_ff     <= plane_dist(seg_in.b);
         side_ff   <= side_in;
         damag_ff  <= damag_in;
         den_ff    <= den_in;
      end
   end

   // Clip parameter t, unsigned Q1.30
   hlc_div #(
      .DenW  (PlDenW),
      .QuoW  (PlQuoW),
      .SideW (SideW)
   ) u_div (
      .clock    (clock),
      .advance  (advance),
      .num      ({{(PlNumW-DistW-TBits){1'b0}}, damag_ff, {TBits{1'b0}}}),
      .den      (den_ff),
      .side_in  (side_ff),
      .quo      (t_quo),
      .rem_nz   (),
      .side_out (div_side_vec)
   );

   assign div_side = div_side_vec;

   // Split |d| * t into two partial products, then sum with rounding
   always_comb begin
      for (int i = 0; i < NumAxes; i++) begin
         ph_in[i] = PhW'(div_side.dmag[i][DistW-1:SplitW]) * PhW'(t_quo);
         pl_in[i] = PlW'(div_side.dmag[i][SplitW-1:0]) * PlW'(t_quo);
         sum[i]   = {ph_ff[i], {SplitW{1'b0}}} + ProdW'(pl_ff[i])
                  + (ProdW'(1) << (TBits - 1));
         q_in[i]  = sum[i][TBits+DistW-1:TBits];
      end
   end

   // Move the outside endpoint to the crossing point
   always_comb begin
      seg_in2 = m1_side_ff.seg;
      for (int i = 0; i < NumAxes; i++) begin
         if (m1_side_ff.dneg[i]) begin
            p_new[i] = PlDenW'($signed(m1_side_ff.seg.a[i])) - PlDenW'(q_ff[i]);
         end else begin
            p_new[i] = PlDenW'($signed(m1_side_ff.seg.a[i])) + PlDenW'(q_ff[i]);
         end
         if (m1_side_ff.move) begin
            if (m1_side_ff.sel_a) begin
               seg_in2.a[i] = p_new[i][CoordW-1:0];
            end else begin
               seg_in2.b[i] = p_new[i][CoordW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NumAxes; i++) begin
            ph_ff[i] <= ph_in[i];
            pl_ff[i] <= pl_in[i];
            q_ff[i]  <= q_in[i];
         end
         m0_side_ff <= div_side;
         m1_side_ff <= m0_side_ff;
         seg_ff     <= seg_in2;
      end
   end

   assign out_valid = m2_valid_ff;
   assign seg_out   = seg_ff;

endmodule

// ----- design/hlc_map.sv -----
// Perspective divide and viewport mapping of a clipped segment, four lanes
// (x0, y0, x1, y1) in lockstep, with rounding and saturation to Q13.4.
// Depends on hlc_pkg and hlc_div.
`timescale 1ns / 1ps

module hlc_map
   import hlc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  seg_type          seg_in,
   input  logic [OffW-1:0]  view_x,
   input  logic [OffW-1:0]  view_y,
   input  logic [SizeW-1:0] view_width,
   input  logic [SizeW-1:0] view_height,
   output logic             out_valid,
   output logic             visible,
   output screen_type       screen
);

   localparam int PreN   = 6;
   localparam int MapLat = PreN + MapQuoW + 2;
   localparam int NfW    = DistW + 1;
   localparam int ProdW  = SizeW + 1 + NfW;
   localparam int NumW   = MapNumW + 1;
   localparam int QmW    = MapQuoW + 1;
   localparam int ResW   = QmW + 2;

   logic [MapLat-1:0] valid_ff, vis_ff;
   logic              vis_in;

   logic signed [DistW-1:0]  n0_in   [NumLanes];
   logic signed [DistW-1:0]  n0_ff   [NumLanes];
   logic signed [CoordW-1:0] w0_in   [NumLanes];
   logic signed [CoordW-1:0] w0_ff   [NumLanes];
   logic signed [NfW-1:0]    nf_ff   [NumLanes];
   logic [CoordW-1:0]        wm1_ff  [NumLanes];
   logic signed [ProdW-1:0]  prod_ff [NumLanes];
   logic [CoordW-1:0]        wm2_ff  [NumLanes];
   logic signed [NumW-1:0]   num_ff  [NumLanes];
   logic [CoordW-1:0]        wm3_ff  [NumLanes];
   logic [MapNumW-1:0]       nmag_ff [NumLanes];
   logic                     neg4_ff [NumLanes];
   logic [MapDenW-1:0]       den4_ff [NumLanes];
   logic [MapNumW-1:0]       dnum_ff [NumLanes];
   logic                     neg5_ff [NumLanes];
   logic                     ovf5_ff [NumLanes];
   logic [MapDenW-1:0]       den5_ff [NumLanes];
   logic [MapQuoW-1:0]       dquo    [NumLanes];
   logic                     drem_nz [NumLanes];
   logic [1:0]               dside   [NumLanes];
   logic [QmW-1:0]           qmag_ff [NumLanes];
   logic                     negy_ff [NumLanes];
   logic                     ovfy_ff [NumLanes];
   logic [ScreenW-1:0]       scr_in  [NumLanes];
   logic [ScreenW-1:0]       scr_ff  [NumLanes];
   logic signed [ResW-1:0]   res     [NumLanes];
   logic [OffW+3:0]          off16   [NumLanes];

   // Visible when not rejected and both endpoint w are nonzero
   assign vis_in = !seg_in.dead && (seg_in.a[IDX_W] != '0) && (seg_in.b[IDX_W] != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[MapLat-2:0], in_valid};
      end
   end

   // Lane numerators: x lanes use w + x, y lanes use w - y (flipped)
   always_comb begin
      point_type pt;
      for (int l = 0; l < NumLanes; l++) begin
         pt       = (l < 2) ? seg_in.a : seg_in.b;
         w0_in[l] = $signed(pt[IDX_W]);
         if (l % 2 == 0) begin
            n0_in[l] = DistW'($signed(pt[IDX_W])) + DistW'($signed(pt[IDX_X]));
         end else begin
            n0_in[l] = DistW'($signed(pt[IDX_W])) - DistW'($signed(pt[IDX_Y]));
         end
      end
   end

   // Final saturating add of the viewport offset
   always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
         off16[l] = {((l % 2 == 0) ? view_x : view_y), 4'b0000};
         if (negy_ff[l]) begin
            res[l] = ResW'(off16[l]) - ResW'(qmag_ff[l]);
         end else begin
            res[l] = ResW'(off16[l]) + ResW'(qmag_ff[l]);
         end
         if (!vis_ff[MapLat-2]) begin
            scr_in[l] = '0;
         end else if (ovfy_ff[l]) begin
            scr_in[l] = negy_ff[l] ? '0 : SCREEN_MAX;
         end else if (res[l] < 0) begin
            scr_in[l] = '0;
         end else if (res[l] > ResW'(SCREEN_MAX)) begin
            scr_in[l] = SCREEN_MAX;
         end else begin
            scr_in[l] = res[l][ScreenW-1:0];
         end
      end
   end

   // Stages: sign fold, scale, add, magnitude, range check, floor, output
   always_ff @(posedge clock) begin
      if (advance) begin
         vis_ff <= {vis_ff[MapLat-2:0], vis_in};
         for (int l = 0; l < NumLanes; l++) begin
            n0_ff[l]  <= n0_in[l];
            w0_ff[l]  <= w0_in[l];
            nf_ff[l]  <= w0_ff[l][CoordW-1] ? -NfW'(n0_ff[l]) : NfW'(n0_ff[l]);
            wm1_ff[l] <= w0_ff[l][CoordW-1] ? CoordW'(-w0_ff[l]) : CoordW'(w0_ff[l]);
            prod_ff[l] <= $signed({1'b0, ((l % 2 == 0) ? view_width : view_height)})
                        * nf_ff[l];
            wm2_ff[l]  <= wm1_ff[l];
            num_ff[l]  <= ($signed(NumW'(prod_ff[l])) <<< 4)
                        + $signed({{(NumW-CoordW){1'b0}}, wm2_ff[l]});
            wm3_ff[l]  <= wm2_ff[l];
            neg4_ff[l] <= num_ff[l][NumW-1];
            nmag_ff[l] <= num_ff[l][NumW-1] ? MapNumW'(-num_ff[l]) : MapNumW'(num_ff[l]);
            den4_ff[l] <= {wm3_ff[l], 1'b0};
            ovf5_ff[l] <= nmag_ff[l] >= {den4_ff[l], {MapQuoW{1'b0}}};
            dnum_ff[l] <= (nmag_ff[l] >= {den4_ff[l], {MapQuoW{1'b0}}}) ? '0 : nmag_ff[l];
            neg5_ff[l] <= neg4_ff[l];
            den5_ff[l] <= den4_ff[l];
            // floor for negative numerators: bump magnitude on a remainder
            qmag_ff[l] <= QmW'(dquo[l]) + QmW'(dside[l][1] & drem_nz[l]);
            negy_ff[l] <= dside[l][1];
            ovfy_ff[l] <= dside[l][0];
            scr_ff[l]  <= scr_in[l];
         end
      end
   end

   for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      hlc_div #(
         .DenW  (MapDenW),
         .QuoW  (MapQuoW),
         .SideW (2)
      ) u_div (
         .clock    (clock),
         .advance  (advance),
         .num      (dnum_ff[l]),
         .den      (den5_ff[l]),
         .side_in  ({neg5_ff[l], ovf5_ff[l]}),
         .quo      (dquo[l]),
         .rem_nz   (drem_nz[l]),
         .side_out (dside[l])
      );
      assign screen[l] = scr_ff[l];
   end

   assign out_valid = valid_ff[MapLat-1];
   assign visible   = vis_ff[MapLat-1];

endmodule

// ----- design/homogeneous_line_clip_to_screen.sv -----
// Homogeneous clip-space line clipper with viewport mapping.
// Input transfer on req_*: one segment as two Q16.16 points (x, y, z, w).
// Output transfer on rsp_*: visible flag and two Q13.4 screen points.
// Configuration on csr_*: viewport x, y, width, height (index 0..3);
// csr_ready is always high, write only while the pipeline is empty.
// Throughput: one segment per cycle while rsp_stall does not freeze the
// pipeline. Path from input transfer to rsp_valid: six plane stages (a
// 31-step clip parameter divider each), a viewport stage with an 18-step
// divider, and the output register.
// Reset (synchronous, active high) empties the pipeline and loads the
// viewport to 0, 0, 640, 480.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall rises; nothing is lost or repeated, and a result waiting in
// the output register never blocks intake while rsp_valid is low.
// Depends on hlc_pkg, hlc_plane, hlc_map, hlc_div.
`timescale 1ns / 1ps

module homogeneous_line_clip_to_screen
   import hlc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CoordW-1:0]   req_start_x,
   input  logic [CoordW-1:0]   req_start_y,
   input  logic [CoordW-1:0]   req_start_z,
   input  logic [CoordW-1:0]   req_start_w,
   input  logic [CoordW-1:0]   req_end_x,
   input  logic [CoordW-1:0]   req_end_y,
   input  logic [CoordW-1:0]   req_end_z,
   input  logic [CoordW-1:0]   req_end_w,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_visible,
   output logic [ScreenW-1:0]  rsp_screen_x0,
   output logic [ScreenW-1:0]  rsp_screen_y0,
   output logic [ScreenW-1:0]  rsp_screen_x1,
   output logic [ScreenW-1:0]  rsp_screen_y1,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   logic              advance;
   logic [OffW-1:0]   view_x_ff, view_y_ff;
   logic [SizeW-1:0]  view_width_ff, view_height_ff;

   seg_type           seg_chain [NumPlanes+1];
   logic [NumPlanes:0] vld_chain;

   logic              map_valid, map_visible;
   screen_type        map_screen;

   logic              rsp_valid_ff, rsp_visible_ff;
   screen_type        rsp_screen_ff;

   // Pipeline moves unless a finished result is held by the receiver
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // Viewport registers
   always_ff @(posedge clock) begin
      if (reset) begin
         view_x_ff      <= '0;
         view_y_ff      <= '0;
         view_width_ff  <= RESET_WIDTH;
         view_height_ff <= RESET_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VIEW_X:      view_x_ff      <= csr_wdata[OffW-1:0];
            CSR_VIEW_Y:      view_y_ff      <= csr_wdata[OffW-1:0];
            CSR_VIEW_WIDTH:  view_width_ff  <= csr_wdata[SizeW-1:0];
            CSR_VIEW_HEIGHT: view_height_ff <= csr_wdata[SizeW-1:0];
         endcase
      end
   end

   // Input segment
   always_comb begin
      seg_chain[0].dead = 1'b0;
      seg_chain[0].a    = {req_start_w, req_start_z, req_start_y, req_start_x};
      seg_chain[0].b    = {req_end_w, req_end_z, req_end_y, req_end_x};
   end
   assign vld_chain[0] = req_valid;

   // Six planes in clipping order
   for (genvar p = 0; p < NumPlanes; p++) begin : g_plane
      hlc_plane #(
         .Plane (p)
      ) u_plane (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (vld_chain[p]),
         .seg_in    (seg_chain[p]),
         .out_valid (vld_chain[p+1]),
         .seg_out   (seg_chain[p+1])
      );
   end

   hlc_map u_map (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (vld_chain[NumPlanes]),
      .seg_in      (seg_chain[NumPlanes]),
      .view_x      (view_x_ff),
      .view_y      (view_y_ff),
      .view_width  (view_width_ff),
      .view_height (view_height_ff),
      .out_valid   (map_valid),
      .visible     (map_visible),
      .screen      (map_screen)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= map_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_visible_ff <= map_visible;
         rsp_screen_ff  <= map_screen;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_visible   = rsp_visible_ff;
   assign rsp_screen_x0 = rsp_screen_ff[0];
   assign rsp_screen_y0 = rsp_screen_ff[1];
   assign rsp_screen_x1 = rsp_screen_ff[2];
   assign rsp_screen_y1 = rsp_screen_ff[3];

endmodule
